// File: rtl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types, codes and color helpers for the palette RAM color converter.
// ----------------------------------------------------------------------------
package prc_pkg;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FETCH = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    BANK_FG  = 2'd0,
    BANK_SPR = 2'd1,
    BANK_BG1 = 2'd2,
    BANK_BG2 = 2'd3
  } bank_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUSY
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic clr_step;  // write zero at the clear pointer, advance it
    logic accept;    // input beat taken this cycle
    logic load_out;  // move the staged result into the output register
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;  // clear pointer at the last entry
  } dp_status_t;

  // Resistor weights for bits 0..3 of a channel nibble
  localparam logic [7:0] W_BIT0 = 8'h0e;
  localparam logic [7:0] W_BIT1 = 8'h1f;
  localparam logic [7:0] W_BIT2 = 8'h43;
  localparam logic [7:0] W_BIT3 = 8'h8f;

  localparam logic [11:0] DARK_COLOR = 12'h003;
  localparam logic [3:0]  DARK_LIMIT = 4'd3;
  localparam logic [3:0]  LAST_SLOT  = 4'd15;
  localparam logic [3:0]  SPR_FLIP   = 4'd15;

  // Weights sum to exactly 0xff, so no carry out of 8 bits
  function automatic logic [7:0] weigh(input logic [3:0] nib);
    logic [7:0] acc;
    acc = nib[0] ? W_BIT0 : 8'h00;
    acc = acc + (nib[1] ? W_BIT1 : 8'h00);
    acc = acc + (nib[2] ? W_BIT2 : 8'h00);
    acc = acc + (nib[3] ? W_BIT3 : 8'h00);
    return acc;
  endfunction

  function automatic logic near_black(input logic [11:0] c);
    return (c[3:0] < DARK_LIMIT) && (c[7:4] < DARK_LIMIT) && (c[11:8] < DARK_LIMIT);
  endfunction

endpackage

// File: rtl/prc_ctrl.sv
// ----------------------------------------------------------------------------
// prc_ctrl
// Sequencer: post-reset RAM clear, item accept, result hand-off to the
// output register.
// ----------------------------------------------------------------------------
module prc_ctrl import prc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_BUSY;
      end
      ST_BUSY: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_BUSY: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/prc_datapath.sv
// ----------------------------------------------------------------------------
// prc_datapath
// Palette word RAM, dirty flags, near-black substitution, channel weighting
// and the result register.
// ----------------------------------------------------------------------------
module prc_datapath import prc_pkg::*; #(
  parameter int COLORS_PER_BANK   = 256,
  parameter int PALETTES_PER_BANK = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_cmd_t   cmd_i,
  output dp_status_t  status_o,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic [1:0]  opcode_i,
  input  logic [1:0]  bank_i,
  input  logic [7:0]  word_index_i,
  input  logic [15:0] data_i,
  output logic [15:0] read_data_o,
  output logic        color_valid_o,
  output logic [7:0]  color_index_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [15:0] dirty_mask_o
);

  localparam int IDX_W  = $clog2(COLORS_PER_BANK);
  localparam int ADDR_W = IDX_W + 2;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int PAL_N  = PALETTES_PER_BANK;
  localparam int SLOTS  = 3;
  localparam logic [8:0] COLOR_LIM = 9'(COLORS_PER_BANK);
  localparam logic [4:0] PAL_LIM   = 5'(PALETTES_PER_BANK);

  // ---------------------------------------------------------------- config
  logic dark_fix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dark_fix_q <= 1'b1;
    end else if (cfg_we_i) begin
      dark_fix_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------- decode
  logic              is_read, is_write, is_fetch;
  logic              idx_ok, pal_ok, last_slot;
  logic [ADDR_W-1:0] addr;
  logic [SLOTS-1:0]  slot_hit;
  logic [PAL_N-1:0]  pal_sel;

  assign is_read   = cmd_i.accept && (opcode_i == OP_READ);
  assign is_write  = cmd_i.accept && (opcode_i == OP_WRITE);
  assign is_fetch  = cmd_i.accept && (opcode_i == OP_FETCH);
  assign idx_ok    = {1'b0, word_index_i} < COLOR_LIM;
  assign pal_ok    = {1'b0, word_index_i[7:4]} < PAL_LIM;
  assign last_slot = word_index_i[3:0] == LAST_SLOT;
  assign addr      = {bank_i, word_index_i[IDX_W-1:0]};

  assign slot_hit[0] = bank_i == BANK_FG;
  assign slot_hit[1] = bank_i == BANK_BG1;
  assign slot_hit[2] = bank_i == BANK_BG2;

  always_comb begin
    for (int p = 0; p < PAL_N; p++) begin
      pal_sel[p] = word_index_i[7:4] == 4'(p);
    end
  end

  // ---------------------------------------------------------------- RAM
  logic [15:0]       mem_q [DEPTH];
  logic [15:0]       mem_rdata_q;
  logic [ADDR_W-1:0] clr_cnt_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign status_o.clr_last = clr_cnt_q == '1;

  assign mem_we    = cmd_i.clr_step || (is_write && idx_ok);
  assign mem_waddr = cmd_i.clr_step ? clr_cnt_q : addr;
  assign mem_wdata = cmd_i.clr_step ? 16'h0000 : data_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (cmd_i.accept) mem_rdata_q <= mem_q[addr];
  end

  // ---------------------------------------------------------------- dirty
  logic [PAL_N-1:0] dirty_q [SLOTS];
  logic [PAL_N-1:0] dirty_d [SLOTS];
  logic [PAL_N-1:0] dirty_cur;

  always_comb begin
    dirty_cur = '0;
    for (int s = 0; s < SLOTS; s++) begin
      dirty_d[s] = dirty_q[s];
      if (slot_hit[s]) begin
        dirty_cur = dirty_q[s];
        if (is_write && idx_ok && pal_ok) dirty_d[s] = dirty_q[s] | pal_sel;
        if (is_fetch) dirty_d[s] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SLOTS; s++) dirty_q[s] <= '0;
    end else begin
      for (int s = 0; s < SLOTS; s++) dirty_q[s] <= dirty_d[s];
    end
  end

  // ---------------------------------------------------------------- color
  logic [11:0] col;
  logic        subst;
  logic        wr_ok;

  always_comb begin
    subst = 1'b0;
    if (!last_slot) begin
      case (bank_i)
        BANK_FG:  subst = near_black(data_i[11:0]);
        BANK_BG1: subst = data_i == 16'h0000;
        BANK_BG2: subst = dark_fix_q && near_black(data_i[11:0]);
        default:  subst = 1'b0;
      endcase
    end
  end

  assign col   = subst ? DARK_COLOR : data_i[11:0];
  assign wr_ok = is_write && idx_ok;

  // ---------------------------------------------------------------- staging
  logic        st_rd_q;
  logic        st_cv_q;
  logic [7:0]  st_idx_q, st_red_q, st_green_q, st_blue_q;
  logic [15:0] st_mask_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      st_rd_q    <= is_read && idx_ok;
      st_cv_q    <= wr_ok;
      st_idx_q   <= !wr_ok ? 8'h00 :
                    (bank_i == BANK_SPR) ? {word_index_i[7:4], word_index_i[3:0] ^ SPR_FLIP} :
                    word_index_i;
      st_red_q   <= wr_ok ? weigh(col[3:0])  : 8'h00;
      st_green_q <= wr_ok ? weigh(col[7:4])  : 8'h00;
      st_blue_q  <= wr_ok ? weigh(col[11:8]) : 8'h00;
      st_mask_q  <= is_fetch ? 16'(dirty_cur) : 16'h0000;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      read_data_o   <= st_rd_q ? mem_rdata_q : 16'h0000;
      color_valid_o <= st_cv_q;
      color_index_o <= st_idx_q;
      red_o         <= st_red_q;
      green_o       <= st_green_q;
      blue_o        <= st_blue_q;
      dirty_mask_o  <= st_mask_q;
    end
  end

endmodule

// File: rtl/palette_ram_color_converter_top.sv
// ----------------------------------------------------------------------------
// palette_ram_color_converter_top
// Four-bank palette word RAM with dirty flags and RGB444 to 8-bit color
// conversion.
//
//   channel  handshake                 payload
//   in       in_valid_i / in_ready_o   opcode_i bank_i word_index_i data_i
//   out      out_valid_o / out_ready_i read_data_o color_valid_o color_index_o
//                                      red_o green_o blue_o dirty_mask_o
//   cfg      cfg_we_i                  cfg_wdata_i (dark_fix_bg2)
//
// An item is accepted with its RAM read and staged result registered, then it is
// handed to the output register; the next item is taken only after that
// hand-off, which waits while the output register holds an untaken result.
// After reset a clearing pass writes zero to all 4 * 2**clog2(COLORS_PER_BANK)
// entries (1024 at default), one per cycle, with in_ready_o low.
// A result waiting in the output register does not block the next accept;
// only the hand-off into that register stalls.
// ----------------------------------------------------------------------------
module palette_ram_color_converter_top import prc_pkg::*; #(
  parameter int COLORS_PER_BANK   = 256,
  parameter int PALETTES_PER_BANK = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [1:0]  bank_i,
  input  logic [7:0]  word_index_i,
  input  logic [15:0] data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] read_data_o,
  output logic        color_valid_o,
  output logic [7:0]  color_index_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [15:0] dirty_mask_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  prc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  prc_datapath #(
    .COLORS_PER_BANK   (COLORS_PER_BANK),
    .PALETTES_PER_BANK (PALETTES_PER_BANK)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .opcode_i      (opcode_i),
    .bank_i        (bank_i),
    .word_index_i  (word_index_i),
    .data_i        (data_i),
    .read_data_o   (read_data_o),
    .color_valid_o (color_valid_o),
    .color_index_o (color_index_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .dirty_mask_o  (dirty_mask_o)
  );

endmodule
